// File: rtl/cst_pkg.sv
// Shared types, constants and character classes of the command string tokenizer.
// No dependencies; every other file but cst_ram imports this package.
package cst_pkg;

  localparam int CST_MAX_LEN = 64;
  localparam int RESULT_CAP  = 64;
  localparam int FCW         = $clog2(RESULT_CAP + 1);

  localparam int CH_W   = 8;
  localparam int OFF_W  = 6;
  localparam int LEN_W  = 7;
  localparam int KIND_W = 3;
  localparam int TOT_W  = 7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_Z_UP   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_Z_LO   = 8'h7A;

  typedef enum logic [2:0] {
    K_PUNCT  = 3'd0,
    K_IDENT  = 3'd1,
    K_NUMBER = 3'd2,
    K_STRING = 3'd3,
    K_OTHER  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_MINUS  = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  prev_bs;
    logic  fin;
  } scan_ctl_t;

  typedef struct packed {
    mode_t mode;
    logic  prev_bs;
    logic  repl;
    logic  v0;
    kind_t k0;
    logic  v1;
    kind_t k1;
  } scan_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] c);
    return ((c >= CH_A_UP) && (c <= CH_Z_UP)) || ((c >= CH_A_LO) && (c <= CH_Z_LO)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_DOT) || (c == CH_COMMA) ||
           (c == CH_EQUAL);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return is_punct(c) || is_blank(c) || (c == CH_QUOTE) || (c == CH_MINUS);
  endfunction

endpackage

// File: rtl/cst_ifs.sv
// Request channel interfaces of the command string tokenizer: byte in, token out.
// Depends on cst_pkg for field widths.
interface cst_in_if import cst_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              token_valid;
  logic [OFF_W-1:0]  token_offset;
  logic [LEN_W-1:0]  token_length;
  logic [KIND_W-1:0] token_kind;
  logic              end_of_command;
  logic [TOT_W-1:0]  token_total;
  logic              overflow;
  logic              run_last;

  modport source (output valid, output token_valid, output token_offset, output token_length,
                  output token_kind, output end_of_command, output token_total,
                  output overflow, output run_last, input ready);
  modport sink (input valid, input token_valid, input token_offset, input token_length,
                input token_kind, input end_of_command, input token_total,
                input overflow, input run_last, output ready);
endinterface

// File: rtl/command_string_tokenizer_top.sv
// Command string tokenizer: bytes in, tokens out, line store in a RAM.
// Depends on cst_pkg, cst_ifs, cst_ram and cst_scan.
//
//   channel   dir  handshake      payload
//   in_bus    in   valid/ready    ch (0 ends the command)
//   out_bus   out  valid/ready    token fields, end_of_command, token_total, run_last
//
// A byte that completes no token goes straight back to S_IN; one that completes k <= 2
// tokens passes S_PUSH, where the result queue feeds the staged output register, then
// S_FLUSH. The terminator passes S_FIN, S_PUSH if it closes a token, and S_FLUSH; an
// unclosed quote re-reads each later byte from the line store via S_RD, S_RDW, S_PUSH.
// Reset is synchronous and clears the scanner, counters, result queue and both valid bits.
// A stalled out_bus holds the block until the last result is in the output register.
module command_string_tokenizer_top import cst_pkg::*; #(
  parameter int MAX_LEN = CST_MAX_LEN
) (
  input logic       clk,
  input logic       rst_n,
  cst_in_if.sink    in_bus,
  cst_out_if.source out_bus
);

  localparam int PW = $clog2(MAX_LEN);

  typedef enum logic [2:0] {
    S_IN,
    S_FIN,
    S_RD,
    S_RDW,
    S_PUSH,
    S_FLUSH
  } state_t;

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic          prev_bs_r, prev_bs_nxt;
  logic [PW-1:0] tstart_r, tstart_nxt;
  logic [PW:0]   bpos_r, bpos_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ended_r, ended_nxt;
  logic          repl_r, repl_nxt;
  logic [PW:0]   cur_r, cur_nxt;
  logic [FCW-1:0] fin_cnt_r, fin_cnt_nxt;

  logic          q0_v_r, q0_v_nxt;
  logic [PW-1:0] q0_s_r, q0_s_nxt;
  logic [PW:0]   q0_l_r, q0_l_nxt;
  kind_t         q0_k_r, q0_k_nxt;
  logic          q1_v_r, q1_v_nxt;
  logic [PW-1:0] q1_s_r, q1_s_nxt;
  kind_t         q1_k_r, q1_k_nxt;

  logic          st_v_r, st_v_nxt;
  logic [PW-1:0] st_s_r, st_s_nxt;
  logic [PW:0]   st_l_r, st_l_nxt;
  kind_t         st_k_r, st_k_nxt;

  logic              out_v_r, out_v_nxt;
  logic              o_tv_r, o_tv_nxt;
  logic [OFF_W-1:0]  o_off_r, o_off_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  kind_t             o_kind_r, o_kind_nxt;
  logic              o_eoc_r, o_eoc_nxt;
  logic [TOT_W-1:0]  o_tot_r, o_tot_nxt;
  logic              o_ovf_r, o_ovf_nxt;
  logic              o_last_r, o_last_nxt;

  logic            out_free;
  logic            take_scan;
  logic            ram_we;
  logic [CH_W-1:0] ram_rdata;

  scan_ctl_t     scan_ctl;
  scan_res_t     scan_res;
  logic [7:0]    scan_b;
  logic [PW-1:0] scan_pos;
  logic [PW-1:0] scan_s0;
  logic [PW:0]   scan_l0;
  logic [PW-1:0] scan_tstart;

  cst_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_LEN)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bpos_r[PW-1:0]),
    .wdata (in_bus.ch),
    .raddr (cur_r[PW-1:0]),
    .rdata (ram_rdata)
  );

  assign scan_ctl.mode    = mode_r;
  assign scan_ctl.prev_bs = prev_bs_r;
  assign scan_ctl.fin     = (state_r == S_FIN);
  assign scan_b           = (state_r == S_RDW) ? ram_rdata : in_bus.ch;
  assign scan_pos         = (state_r == S_RDW) ? cur_r[PW-1:0] : bpos_r[PW-1:0];

  cst_scan #(
    .PW (PW)
  ) u_scan (
    .ctl_i    (scan_ctl),
    .tstart_i (tstart_r),
    .b_i      (scan_b),
    .pos_i    (scan_pos),
    .end_i    (bpos_r),
    .res_o    (scan_res),
    .s0_o     (scan_s0),
    .l0_o     (scan_l0),
    .tstart_o (scan_tstart)
  );

  assign out_free = !out_v_r || out_bus.ready;

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    prev_bs_nxt = prev_bs_r;
    tstart_nxt  = tstart_r;
    bpos_nxt    = bpos_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    ended_nxt   = ended_r;
    repl_nxt    = repl_r;
    cur_nxt     = cur_r;
    fin_cnt_nxt = fin_cnt_r;
    q0_v_nxt    = q0_v_r;
    q0_s_nxt    = q0_s_r;
    q0_l_nxt    = q0_l_r;
    q0_k_nxt    = q0_k_r;
    q1_v_nxt    = q1_v_r;
    q1_s_nxt    = q1_s_r;
    q1_k_nxt    = q1_k_r;
    st_v_nxt    = st_v_r;
    st_s_nxt    = st_s_r;
    st_l_nxt    = st_l_r;
    st_k_nxt    = st_k_r;
    out_v_nxt   = out_v_r && !out_bus.ready;
    o_tv_nxt    = o_tv_r;
    o_off_nxt   = o_off_r;
    o_len_nxt   = o_len_r;
    o_kind_nxt  = o_kind_r;
    o_eoc_nxt   = o_eoc_r;
    o_tot_nxt   = o_tot_r;
    o_ovf_nxt   = o_ovf_r;
    o_last_nxt  = o_last_r;
    take_scan   = 1'b0;
    ram_we      = 1'b0;

    unique case (state_r)
      S_IN: begin
        if (in_bus.valid) begin
          if (in_bus.ch == CH_NUL) begin
            ended_nxt   = 1'b1;
            fin_cnt_nxt = '0;
            state_nxt   = S_FIN;
          end else if (bpos_r == (PW+1)'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            take_scan = 1'b1;
            bpos_nxt  = bpos_r + (PW+1)'(1);
            state_nxt = scan_res.v0 ? S_PUSH : S_IN;
          end
        end
      end
      S_FIN: begin
        take_scan = 1'b1;
        repl_nxt  = scan_res.repl;
        if (scan_res.repl) begin
          cur_nxt = {1'b0, tstart_r} + (PW+1)'(1);
        end
        state_nxt = scan_res.v0 ? S_PUSH : S_FLUSH;
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        take_scan = 1'b1;
        cur_nxt   = cur_r + (PW+1)'(1);
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (ended_r && (fin_cnt_r == FCW'(RESULT_CAP))) begin
          // drop everything past the result cap on tokens found after the terminator
          q0_v_nxt  = 1'b0;
          q1_v_nxt  = 1'b0;
          state_nxt = S_FLUSH;
        end else if (q0_v_r) begin
          if (!st_v_r || out_free) begin
            if (st_v_r) begin
              out_v_nxt  = 1'b1;
              o_tv_nxt   = 1'b1;
              o_off_nxt  = OFF_W'(st_s_r);
              o_len_nxt  = LEN_W'(st_l_r);
              o_kind_nxt = st_k_r;
              o_eoc_nxt  = 1'b0;
              o_tot_nxt  = '0;
              o_ovf_nxt  = ovf_r;
              o_last_nxt = 1'b0;
            end
            st_v_nxt = 1'b1;
            st_s_nxt = q0_s_r;
            st_l_nxt = q0_l_r;
            st_k_nxt = q0_k_r;
            cnt_nxt  = cnt_r + (PW+1)'(1);
            if (ended_r) begin
              fin_cnt_nxt = fin_cnt_r + FCW'(1);
            end
            q0_v_nxt = q1_v_r;
            q0_s_nxt = q1_s_r;
            q0_l_nxt = (PW+1)'(1);
            q0_k_nxt = q1_k_r;
            q1_v_nxt = 1'b0;
          end
        end else if (ended_r && repl_r) begin
          state_nxt = (cur_r < bpos_r) ? S_RD : S_FIN;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st_v_r && !ended_r) begin
          state_nxt = S_IN;
        end else if (out_free) begin
          out_v_nxt  = 1'b1;
          o_tv_nxt   = st_v_r;
          o_off_nxt  = st_v_r ? OFF_W'(st_s_r) : '0;
          o_len_nxt  = st_v_r ? LEN_W'(st_l_r) : '0;
          o_kind_nxt = st_v_r ? st_k_r : K_PUNCT;
          o_eoc_nxt  = ended_r;
          o_tot_nxt  = ended_r ? TOT_W'(cnt_r) : '0;
          o_ovf_nxt  = ovf_r;
          o_last_nxt = 1'b1;
          st_v_nxt   = 1'b0;
          state_nxt  = S_IN;
          if (ended_r) begin
            mode_nxt    = M_IDLE;
            prev_bs_nxt = 1'b0;
            tstart_nxt  = '0;
            bpos_nxt    = '0;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            ended_nxt   = 1'b0;
            repl_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase

    if (take_scan) begin
      mode_nxt    = scan_res.mode;
      prev_bs_nxt = scan_res.prev_bs;
      tstart_nxt  = scan_tstart;
      q0_v_nxt    = scan_res.v0;
      q0_s_nxt    = scan_s0;
      q0_l_nxt    = scan_l0;
      q0_k_nxt    = scan_res.k0;
      q1_v_nxt    = scan_res.v1;
      q1_s_nxt    = scan_pos;
      q1_k_nxt    = scan_res.k1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IN;
      mode_r    <= M_IDLE;
      prev_bs_r <= 1'b0;
      tstart_r  <= '0;
      bpos_r    <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      ended_r   <= 1'b0;
      repl_r    <= 1'b0;
      cur_r     <= '0;
      fin_cnt_r <= '0;
      q0_v_r    <= 1'b0;
      q1_v_r    <= 1'b0;
      st_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      prev_bs_r <= prev_bs_nxt;
      tstart_r  <= tstart_nxt;
      bpos_r    <= bpos_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      ended_r   <= ended_nxt;
      repl_r    <= repl_nxt;
      cur_r     <= cur_nxt;
      fin_cnt_r <= fin_cnt_nxt;
      q0_v_r    <= q0_v_nxt;
      q1_v_r    <= q1_v_nxt;
      st_v_r    <= st_v_nxt;
      out_v_r   <= out_v_nxt;
    end
    q0_s_r   <= q0_s_nxt;
    q0_l_r   <= q0_l_nxt;
    q0_k_r   <= q0_k_nxt;
    q1_s_r   <= q1_s_nxt;
    q1_k_r   <= q1_k_nxt;
    st_s_r   <= st_s_nxt;
    st_l_r   <= st_l_nxt;
    st_k_r   <= st_k_nxt;
    o_tv_r   <= o_tv_nxt;
    o_off_r  <= o_off_nxt;
    o_len_r  <= o_len_nxt;
    o_kind_r <= o_kind_nxt;
    o_eoc_r  <= o_eoc_nxt;
    o_tot_r  <= o_tot_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_bus.ready           = (state_r == S_IN);
  assign out_bus.valid          = out_v_r;
  assign out_bus.token_valid    = o_tv_r;
  assign out_bus.token_offset   = o_off_r;
  assign out_bus.token_length   = o_len_r;
  assign out_bus.token_kind     = o_kind_r;
  assign out_bus.end_of_command = o_eoc_r;
  assign out_bus.token_total    = o_tot_r;
  assign out_bus.overflow       = o_ovf_r;
  assign out_bus.run_last       = o_last_r;

endmodule

// File: rtl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cst_scan.sv
// One scanner step: advances the pending token by one byte, or closes it at the end.
// Depends on cst_pkg for modes, kinds and character classes.
module cst_scan import cst_pkg::*; #(
  parameter int PW = 6
) (
  input  scan_ctl_t       ctl_i,
  input  logic [PW-1:0]   tstart_i,
  input  logic [7:0]      b_i,
  input  logic [PW-1:0]   pos_i,
  input  logic [PW:0]     end_i,
  output scan_res_t       res_o,
  output logic [PW-1:0]   s0_o,
  output logic [PW:0]     l0_o,
  output logic [PW-1:0]   tstart_o
);

  logic  sv;
  kind_t sk;
  mode_t sm;
  logic  close;
  kind_t ck;

  // classify the byte as the start of a new token
  always_comb begin
    sv = 1'b0;
    sk = K_PUNCT;
    sm = M_IDLE;
    if (is_blank(b_i)) begin
      sv = 1'b0;
    end else if (is_punct(b_i)) begin
      sv = 1'b1;
    end else if (b_i == CH_QUOTE) begin
      sm = M_STRING;
    end else if (b_i == CH_MINUS) begin
      sm = M_MINUS;
    end else if (is_digit(b_i)) begin
      sm = M_NUMBER;
    end else if (is_alpha_us(b_i)) begin
      sm = M_IDENT;
    end else begin
      sv = 1'b1;
      sk = K_OTHER;
    end
  end

  always_comb begin
    close = 1'b0;
    ck    = K_OTHER;
    unique case (ctl_i.mode) inside
      M_IDENT: begin
        close = !(is_alpha_us(b_i) || is_digit(b_i));
        ck    = K_IDENT;
      end
      M_NUMBER: begin
        close = is_op(b_i);
        ck    = K_NUMBER;
      end
      M_MINUS: begin
        close = !(is_alpha_us(b_i) || is_digit(b_i));
        ck    = (b_i == CH_DOT) ? K_NUMBER : K_OTHER;
      end
      M_IDLE, M_STRING: begin
        close = 1'b0;
      end
      default: begin
        close = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.mode    = ctl_i.mode;
    res_o.prev_bs = ctl_i.prev_bs;
    res_o.repl    = 1'b0;
    res_o.v0      = 1'b0;
    res_o.k0      = K_PUNCT;
    res_o.v1      = 1'b0;
    res_o.k1      = K_PUNCT;
    s0_o          = tstart_i;
    l0_o          = {1'b0, pos_i} - {1'b0, tstart_i};
    tstart_o      = tstart_i;
    if (ctl_i.fin) begin
      unique case (ctl_i.mode) inside
        M_IDENT, M_NUMBER, M_MINUS: begin
          res_o.v0   = 1'b1;
          res_o.k0   = (ctl_i.mode == M_IDENT) ? K_IDENT :
                       (ctl_i.mode == M_NUMBER) ? K_NUMBER : K_OTHER;
          l0_o       = end_i - {1'b0, tstart_i};
          res_o.mode = M_IDLE;
        end
        M_STRING: begin
          // unclosed quote: one-byte token, rescan what follows it
          res_o.v0   = 1'b1;
          res_o.k0   = K_STRING;
          l0_o       = (PW+1)'(1);
          res_o.repl = 1'b1;
          res_o.mode = M_IDLE;
        end
        M_IDLE: begin
          res_o.mode = M_IDLE;
        end
        default: begin
          res_o.mode = M_IDLE;
        end
      endcase
    end else begin
      unique case (ctl_i.mode) inside
        M_IDLE: begin
          res_o.v0      = sv;
          res_o.k0      = sk;
          s0_o          = pos_i;
          l0_o          = (PW+1)'(1);
          res_o.mode    = sm;
          res_o.prev_bs = 1'b0;
          tstart_o      = pos_i;
        end
        M_STRING: begin
          if ((b_i == CH_QUOTE) && !ctl_i.prev_bs) begin
            res_o.v0   = 1'b1;
            res_o.k0   = K_STRING;
            l0_o       = {1'b0, pos_i} - {1'b0, tstart_i} + (PW+1)'(1);
            res_o.mode = M_IDLE;
          end else begin
            res_o.prev_bs = (b_i == CH_BSLASH);
          end
        end
        M_IDENT, M_NUMBER, M_MINUS: begin
          if (close) begin
            res_o.v0      = 1'b1;
            res_o.k0      = ck;
            res_o.v1      = sv;
            res_o.k1      = sk;
            res_o.mode    = sm;
            res_o.prev_bs = 1'b0;
            tstart_o      = pos_i;
          end else if (ctl_i.mode == M_MINUS) begin
            res_o.mode = is_digit(b_i) ? M_NUMBER : M_IDENT;
          end
        end
        default: begin
          res_o.mode = M_IDLE;
        end
      endcase
    end
  end

endmodule
